// File: hw/rtl/brb_pkg.sv
`default_nettype none

package brb_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int ELEM_BITS_DEF = 8;
  localparam int LANES_DEF     = 8;
  localparam int CAP_RESET     = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // sequencer controls toward the slot store
  typedef struct packed {
    logic load;
    logic issue;
    logic is_write;
  } seq_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/brb_lane.sv
`default_nettype none

module brb_lane #(
  parameter int ELEM_BITS = brb_pkg::ELEM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic                 is_write,
  input  wire logic [ELEM_BITS-1:0] wdata,
  input  wire logic                 cap_en,
  input  wire logic [ELEM_BITS-1:0] rd_word,
  output logic      [ELEM_BITS-1:0] elem
);

  // holds the element to push, or the popped element (zero if this lane pops nothing)
  always_ff @(posedge clk) begin
    if (load) begin
      elem <= is_write ? wdata : '0;
    end else if (cap_en) begin
      elem <= rd_word;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/brb_store.sv
`default_nettype none

module brb_store #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int ELEM_BITS = brb_pkg::ELEM_BITS_DEF,
  parameter int LANES     = brb_pkg::LANES_DEF,
  localparam int AW       = $clog2(DEPTH),
  localparam int LIW      = (LANES > 1) ? $clog2(LANES) : 1,
  localparam int DW       = LANES * ELEM_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire brb_pkg::seq_ctl_t ctl,
  input  wire logic [LIW-1:0]    lane_idx,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [DW-1:0]     wdata,
  output logic      [DW-1:0]     rdata
);

  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [ELEM_BITS-1:0] rd_q;
  logic                 rd_pend;
  logic [LIW-1:0]       rd_idx;
  logic [ELEM_BITS-1:0] lane_elem [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    brb_lane #(
      .ELEM_BITS(ELEM_BITS)
    ) u_lane (
      .clk     (clk),
      .load    (ctl.load),
      .is_write(ctl.is_write),
      .wdata   (wdata[i*ELEM_BITS +: ELEM_BITS]),
      .cap_en  (rd_pend && (rd_idx == LIW'(i))),
      .rd_word (rd_q),
      .elem    (lane_elem[i])
    );
    assign rdata[i*ELEM_BITS +: ELEM_BITS] = lane_elem[i];
  end

  // one element per cycle through the single port
  always_ff @(posedge clk) begin
    if (ctl.issue && ctl.is_write) begin
      mem[addr] <= lane_elem[lane_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue && !ctl.is_write) begin
      rd_q <= mem[addr];
    end
    rd_idx <= lane_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ctl.issue && !ctl.is_write;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/batch_ring_buffer_top.sv
`default_nettype none

// Batch ring buffer. Each item on s_* is a push (s_tuser = 1) or a pop (s_tuser = 0) of up to
// LANES elements; all_or_nothing selects whether a request that does not fully fit moves
// nothing or moves what it can. Every item yields one result on m_* with the moved count, the
// popped elements (zero in lanes that popped nothing and on pushes) and the occupancy after
// the request. The slots live in one single-port memory that moves one element per cycle, so
// the input stays closed while an item passes the RUN, DRAIN and FINISH states (only FINISH
// when nothing moves), and FINISH waits while the previous result still waits in the output
// register; the finished result sits in that register while the next item is taken.
// Writing cfg_wdata sets the wrap point (0 acts as 1, above DEPTH acts as DEPTH) and
// empties the buffer; write it only while no item is in progress.
module batch_ring_buffer_top #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int ELEM_BITS = brb_pkg::ELEM_BITS_DEF,
  parameter int LANES     = brb_pkg::LANES_DEF,
  localparam int AW       = $clog2(DEPTH),
  localparam int CAPW     = $clog2(DEPTH + 1),
  localparam int BCW      = $clog2(LANES + 1),
  localparam int LIW      = (LANES > 1) ? $clog2(LANES) : 1,
  localparam int DW       = LANES * ELEM_BITS,
  localparam int IN_W     = BCW + 1 + DW,
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = BCW + DW + CAPW,
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CAPW-1:0]   cfg_wdata,   // capacity_in_use
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_TW-1:0]  s_tdata,     // batch_count, all_or_nothing, wdata0..wdataN
  input  wire logic              s_tuser,     // req_type
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OUT_TW-1:0] m_tdata      // moved_count, rdata0..rdataN, occupancy
);

  localparam int MW = (CAPW > BCW) ? CAPW : BCW;
  localparam logic [CAPW-1:0] CAP_RST =
      CAPW'((brb_pkg::CAP_RESET > DEPTH) ? DEPTH : brb_pkg::CAP_RESET);

  brb_pkg::state_t   state, state_next;
  brb_pkg::seq_ctl_t ctl;

  logic [CAPW-1:0] cap;
  logic [AW-1:0]   rp, wp, addr, addr_adv;
  logic [CAPW-1:0] fill, avail, addr_inc;
  logic            req_write;
  logic [BCW-1:0]  n_reg, cnt, want, n_dec;
  logic            fin, last;
  logic [DW-1:0]   rdata;

  logic [BCW-1:0]  in_count;
  logic            in_strict;
  logic [DW-1:0]   in_wdata;

  assign in_count  = s_tdata[BCW-1:0];
  assign in_strict = s_tdata[BCW];
  assign in_wdata  = s_tdata[BCW+1 +: DW];

  // how many elements this request moves
  always_comb begin
    want  = (in_count > BCW'(LANES)) ? BCW'(LANES) : in_count;
    avail = s_tuser ? (cap - fill) : fill;
    if (MW'(want) > MW'(avail)) begin
      n_dec = in_strict ? '0 : avail[BCW-1:0];
    end else begin
      n_dec = want;
    end
  end

  assign addr_inc = CAPW'({1'b0, addr}) + 1'b1;
  assign addr_adv = (addr_inc == cap) ? '0 : addr_inc[AW-1:0];
  assign last     = (BCW'(cnt + 1'b1) == n_reg);

  always_comb begin
    state_next = state;
    unique case (state)
      brb_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (n_dec == '0) ? brb_pkg::ST_FINISH : brb_pkg::ST_RUN;
        end
      end
      brb_pkg::ST_RUN: begin
        if (last) begin
          state_next = brb_pkg::ST_DRAIN;
        end
      end
      brb_pkg::ST_DRAIN: state_next = brb_pkg::ST_FINISH;
      brb_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: state_next = brb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == brb_pkg::ST_IDLE);
    ctl.load     = (state == brb_pkg::ST_IDLE) && s_tvalid;
    ctl.issue    = (state == brb_pkg::ST_RUN);
    ctl.is_write = (state == brb_pkg::ST_IDLE) ? s_tuser : req_write;
    fin          = (state == brb_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brb_pkg::ST_IDLE;
      cap      <= CAP_RST;
      rp       <= '0;
      wp       <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          cap <= CAPW'(1);
        end else if (cfg_wdata > CAPW'(DEPTH)) begin
          cap <= CAPW'(DEPTH);
        end else begin
          cap <= cfg_wdata;
        end
        rp   <= '0;
        wp   <= '0;
        fill <= '0;
      end else begin
        if (ctl.load) begin
          fill <= s_tuser ? (fill + CAPW'(n_dec)) : (fill - CAPW'(n_dec));
        end
        // the walking address lands on the new pointer after the last element
        if (ctl.issue && last) begin
          if (req_write) begin
            wp <= addr_adv;
          end else begin
            rp <= addr_adv;
          end
        end
      end
      if (fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      n_reg     <= n_dec;
      req_write <= s_tuser;
      cnt       <= '0;
      addr      <= s_tuser ? wp : rp;
    end else if (ctl.issue) begin
      cnt  <= cnt + 1'b1;
      addr <= addr_adv;
    end
    // lanes still hold the pushed elements on a push
    if (fin) begin
      m_tdata <= OUT_TW'({fill, (req_write ? {DW{1'b0}} : rdata), n_reg});
    end
  end

  brb_store #(
    .DEPTH    (DEPTH),
    .ELEM_BITS(ELEM_BITS),
    .LANES    (LANES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .lane_idx(cnt[LIW-1:0]),
    .addr    (addr),
    .wdata   (in_wdata),
    .rdata   (rdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/brb_checker.sv
`default_nettype none

module brb_checker #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int ELEM_BITS = brb_pkg::ELEM_BITS_DEF,
  parameter int LANES     = brb_pkg::LANES_DEF,
  localparam int CAPW     = $clog2(DEPTH + 1),
  localparam int BCW      = $clog2(LANES + 1),
  localparam int DW       = LANES * ELEM_BITS,
  localparam int IN_W     = BCW + 1 + DW,
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = BCW + DW + CAPW,
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cfg_we,
  input wire logic [CAPW-1:0]   cfg_wdata,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic [IN_TW-1:0]  s_tdata,
  input wire logic              s_tuser,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [OUT_TW-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open in the cycle after an accept");

  a_moved_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[BCW-1:0] <= BCW'(LANES)))
    else $error("moved count above lane count");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[BCW+DW +: CAPW] <= CAPW'(DEPTH)))
    else $error("occupancy above depth");

endmodule

bind batch_ring_buffer_top brb_checker #(
  .DEPTH    (DEPTH),
  .ELEM_BITS(ELEM_BITS),
  .LANES    (LANES)
) u_brb_checker (.*);

`default_nettype wire

// File: verif/batch_ring_buffer_top_test.sv
`timescale 1ns / 100ps

module batch_ring_buffer_top_test;

  localparam int DEPTH  = brb_pkg::DEPTH_DEF;
  localparam int EW     = brb_pkg::ELEM_BITS_DEF;
  localparam int LANES  = brb_pkg::LANES_DEF;
  localparam int CAPW   = $clog2(DEPTH + 1);
  localparam int BCW    = $clog2(LANES + 1);
  localparam int DW     = LANES * EW;
  localparam int IN_W   = BCW + 1 + DW;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = BCW + DW + CAPW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic REQ_POP     = 1'b0;
  localparam logic REQ_PUSH    = 1'b1;
  localparam logic PARTIAL     = 1'b0;
  localparam logic ALL_OR_NONE = 1'b1;

  localparam int SETTLE_CYCLES = 14;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LONG_HOLD     = 300;
  localparam int STUCK_LIMIT   = 2000;

  typedef struct packed {
    logic                      is_push;
    logic [LANES-1:0][EW-1:0]  lanes;
    logic                      strict;
    logic [BCW-1:0]            count;
  } batch_req_t;

  // same field order as m_tdata, highest field first
  typedef struct packed {
    logic [CAPW-1:0]           occ;
    logic [LANES-1:0][EW-1:0]  lanes;
    logic [BCW-1:0]            moved;
  } batch_result_t;

  typedef enum logic [1:0] {
    STEP_BATCH,
    STEP_CAP,
    STEP_DRAIN,
    STEP_HOLD
  } step_kind_t;

  typedef struct packed {
    step_kind_t   kind;
    batch_req_t   req;
    logic [CAPW-1:0] cap;
  } step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CAPW-1:0]   cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  batch_ring_buffer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // ring model
  logic [EW-1:0]   slot_mem [DEPTH];
  logic [CAPW-1:0] cap_reg = CAPW'(brb_pkg::CAP_RESET);
  int              rd_ptr = 0;
  int              wr_ptr = 0;
  int              held = 0;

  step_t           request_q [$];
  batch_result_t   batch_results_q [$];

  logic in_taken = 1'b0;
  int   quiet_cycles = 0;
  int   stuck_cycles = 0;
  int   error_count = 0;
  int   result_no = 0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   tx_gap = 0;
  int   tx_steady = 0;
  int   rx_wait = 0;
  int   rx_steady = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic batch_result_t apply_request(batch_req_t rq);
    batch_result_t res;
    int cap;
    int want;
    int room;
    int n;
    int i;
    res = '0;
    cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    want = (rq.count > LANES) ? LANES : int'(rq.count);
    if (held > cap) held = cap;
    room = rq.is_push ? cap - held : held;
    n = want;
    if (n > room) n = rq.strict ? 0 : room;
    for (i = 0; i < n; i++) begin
      if (rq.is_push) slot_mem[(wr_ptr + i) % cap] = rq.lanes[i];
      else res.lanes[i] = slot_mem[(rd_ptr + i) % cap];
    end
    if (rq.is_push) begin
      wr_ptr = (wr_ptr + n) % cap;
      held = held + n;
    end else begin
      rd_ptr = (rd_ptr + n) % cap;
      held = held - n;
    end
    res.moved = BCW'(n);
    res.occ = CAPW'(held);
    return res;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    $display("error: %s", msg);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  task automatic add_batch(logic push, int count, logic strict, logic [DW-1:0] data);
    step_t st;
    st = '0;
    st.kind = STEP_BATCH;
    st.req.is_push = push;
    st.req.count = BCW'(count);
    st.req.strict = strict;
    st.req.lanes = data;
    request_q.push_back(st);
  endtask

  task automatic add_step(step_kind_t kind, int cap);
    step_t st;
    st = '0;
    st.kind = kind;
    st.cap = CAPW'(cap);
    request_q.push_back(st);
  endtask

  task automatic add_random(int n, int push_pct);
    step_t st;
    int r;
    int k;
    for (k = 0; k < n; k++) begin
      st = '0;
      st.kind = STEP_BATCH;
      st.req.is_push = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
      r = $urandom_range(0, 99);
      if (r < 82) st.req.count = BCW'($urandom_range(1, LANES));
      else if (r < 90) st.req.count = '0;
      else st.req.count = BCW'($urandom_range(LANES + 1, (1 << BCW) - 1));
      st.req.strict = ($urandom_range(0, 99) < 30) ? ALL_OR_NONE : PARTIAL;
      st.req.lanes = {$urandom, $urandom};
      request_q.push_back(st);
    end
  endtask

  // sender
  always @(negedge clk) begin
    step_t head;
    logic  go_valid;
    logic  go_we;
    go_valid = s_tvalid && !in_taken;
    go_we = 1'b0;
    if (rst) begin
      go_valid = 1'b0;
    end else if (!go_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (request_q.size() != 0) begin
        head = request_q[0];
        case (head.kind)
          STEP_BATCH: begin
            s_tdata <= IN_TW'({head.req.lanes, head.req.strict, head.req.count});
            s_tuser <= head.req.is_push;
            go_valid = 1'b1;
            void'(request_q.pop_front());
            if (tx_steady > 0) begin
              tx_steady--;
            end else begin
              tx_gap = idle_len();
              if ($urandom_range(0, 49) == 0) tx_steady = $urandom_range(15, 40);
            end
          end
          STEP_CAP: begin
            // block has finished its last item by now
            if (quiet_cycles >= SETTLE_CYCLES) begin
              cfg_wdata <= head.cap;
              go_we = 1'b1;
              void'(request_q.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (batch_results_q.size() == 0) void'(request_q.pop_front());
          end
          default: begin
            hold_asks <= hold_asks + 1;
            void'(request_q.pop_front());
          end
        endcase
      end
    end
    s_tvalid <= go_valid;
    cfg_we <= go_we;
  end

  // receiver
  always @(negedge clk) begin
    logic ready;
    ready = 1'b0;
    if (rst) begin
      ready = 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      rx_wait = LONG_HOLD;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end else if (rx_steady > 0) begin
      rx_steady--;
      ready = 1'b1;
    end else begin
      ready = 1'b1;
      rx_wait = idle_len();
      if ($urandom_range(0, 39) == 0) rx_steady = $urandom_range(20, 60);
    end
    m_tready <= ready;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    batch_req_t    rq;
    batch_result_t got;
    batch_result_t want;
    int            i;
    in_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        rd_ptr = 0;
        wr_ptr = 0;
        held = 0;
      end
      if (s_tvalid && s_tready) begin
        rq.is_push = s_tuser;
        rq.count = s_tdata[BCW-1:0];
        rq.strict = s_tdata[BCW];
        rq.lanes = s_tdata[BCW+1 +: DW];
        batch_results_q.push_back(apply_request(rq));
      end
      if (m_tvalid && m_tready) begin
        got = batch_result_t'(m_tdata[OUT_W-1:0]);
        if (batch_results_q.size() == 0) begin
          log_error($sformatf("result %0d arrived with no request outstanding", result_no));
        end else begin
          want = batch_results_q.pop_front();
          if (got.moved !== want.moved)
            log_error($sformatf("result %0d moved_count %0d, expected %0d",
                                result_no, got.moved, want.moved));
          for (i = 0; i < LANES; i++) begin
            if (got.lanes[i] !== want.lanes[i])
              log_error($sformatf("result %0d rdata%0d 0x%02h, expected 0x%02h",
                                  result_no, i, got.lanes[i], want.lanes[i]));
          end
          if (got.occ !== want.occ)
            log_error($sformatf("result %0d occupancy %0d, expected %0d",
                                result_no, got.occ, want.occ));
        end
        result_no++;
      end
    end
    if (batch_results_q.size() == 0 && !s_tvalid && !cfg_we) quiet_cycles <= quiet_cycles + 1;
    else quiet_cycles <= 0;
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", stuck_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    // empty buffer at the reset capacity
    add_batch(REQ_POP, 8, ALL_OR_NONE, '0);
    add_batch(REQ_POP, 3, PARTIAL, '0);
    add_batch(REQ_PUSH, 0, ALL_OR_NONE, {DW{1'b1}});
    add_batch(REQ_PUSH, 8, ALL_OR_NONE, {DW{1'b1}});
    add_batch(REQ_PUSH, 8, ALL_OR_NONE, '0);
    add_batch(REQ_PUSH, 15, PARTIAL, {$urandom, $urandom});
    add_batch(REQ_PUSH, 4, PARTIAL, {(DW / 16){16'haa55}});
    add_batch(REQ_POP, 0, PARTIAL, '0);
    add_batch(REQ_POP, 15, PARTIAL, '0);
    add_batch(REQ_POP, 8, ALL_OR_NONE, '0);
    add_batch(REQ_POP, 8, ALL_OR_NONE, '0);
    add_batch(REQ_POP, 8, ALL_OR_NONE, '0);
    add_batch(REQ_POP, 5, PARTIAL, '0);
    // zero capacity behaves as a single slot
    add_step(STEP_CAP, 0);
    add_batch(REQ_PUSH, 3, PARTIAL, {$urandom, $urandom});
    add_batch(REQ_PUSH, 1, ALL_OR_NONE, {$urandom, $urandom});
    add_batch(REQ_POP, 2, ALL_OR_NONE, '0);
    add_batch(REQ_POP, 2, PARTIAL, '0);
    // oversize capacity clamps to the full depth
    add_step(STEP_CAP, (1 << CAPW) - 1);
    add_batch(REQ_PUSH, 8, ALL_OR_NONE, {$urandom, $urandom});
    add_step(STEP_DRAIN, 0);
    // small ring, pointers wrap
    add_step(STEP_CAP, 5);
    add_batch(REQ_PUSH, 4, ALL_OR_NONE, {$urandom, $urandom});
    add_batch(REQ_PUSH, 4, PARTIAL, {$urandom, $urandom});
    add_batch(REQ_PUSH, 1, ALL_OR_NONE, {$urandom, $urandom});
    add_batch(REQ_POP, 3, ALL_OR_NONE, '0);
    add_batch(REQ_PUSH, 3, ALL_OR_NONE, {$urandom, $urandom});
    add_batch(REQ_POP, 8, PARTIAL, '0);

    add_step(STEP_CAP, 1);
    add_random(40, 50);
    add_step(STEP_CAP, 2);
    add_random(40, 55);
    add_step(STEP_CAP, 7);
    add_random(30, 60);
    add_step(STEP_DRAIN, 0);
    add_random(30, 45);
    // fill up, then stall the output so the input backs up
    add_step(STEP_CAP, DEPTH);
    add_random(50, 75);
    add_step(STEP_HOLD, 0);
    add_random(60, 80);
    add_random(50, 25);
    add_step(STEP_CAP, 13);
    add_random(50, 50);
    add_step(STEP_CAP, 33);
    add_random(60, 60);
    add_step(STEP_CAP, $urandom_range(3, DEPTH - 1));
    add_random(60, 50);
    add_step(STEP_CAP, DEPTH);
    add_random(30, 50);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0) @(posedge clk);
    do @(negedge clk); while (quiet_cycles < DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
